// File: hw/rtl/pn_pkg.sv
// pn_pkg: shared constants, codes and controller/datapath interface types
// for the path normaliser. Has no dependencies; the files that use it refer
// to it by scoped names or import it.
`default_nettype none

package pn_pkg;

  // Default limit on the normalised path length.
  localparam int unsigned PATH_MAX_DEF = 256;

  // Stream widths: input tdata carries char_in and read_index, output tdata
  // carries done_res, status, length and char_out padded to whole bytes.
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_FIELD_W = 19;
  localparam int unsigned OUT_DATA_W  = 24;

  // Root prefix and special characters.
  localparam int unsigned ROOT_LEN = 4;
  localparam logic [7:0]  CH_SLASH = 8'h2F;
  localparam logic [7:0]  CH_DOT   = 8'h2E;
  localparam logic [7:0]  CH_NUL   = 8'h00;

  // Progress through the root prefix: 0..3 while matching, then these.
  localparam logic [2:0] PM_ROOT  = 3'd4;
  localparam logic [2:0] PM_ENDED = 3'd5;

  // Status codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NO_ROOT  = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;

  // How the datapath classifies the latched push byte.
  typedef enum logic [2:0] {
    BK_SKIP,   // path already ended or in error: byte ignored
    BK_ROOT,   // still matching the root prefix
    BK_SEP,    // separator or terminating zero: closes the segment
    BK_NEW,    // first character of a segment: needs a slash first
    BK_MORE    // further character of a segment
  } byte_kind_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,  // take the beat; a push after a finished path opens a new one
    CMD_ROOT,   // compare against the root prefix
    CMD_SLASH,  // write the separating slash of a new segment
    CMD_CHAR,   // append the latched character
    CMD_FIN,    // mark the path finished
    CMD_SEG,    // close the current segment
    CMD_WREQ,   // rollback: read the character below the current length
    CMD_WSTEP,  // rollback: step the length back by one
    CMD_READ,   // read item: fetch the requested character
    CMD_LOAD    // load the output register
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic       op_read;
    logic       is_last;
    byte_kind_t kind;
    logic       need_endseg;
    logic       seg_dotdot;
    logic       len_above_root;
    logic       rd_slash;
  } st_t;

  function automatic logic [7:0] root_char(input logic [1:0] i);
    logic [7:0] ch;
    case (i)
      2'd0:    ch = 8'h2F;  // '/'
      2'd1:    ch = 8'h6C;  // 'l'
      2'd2:    ch = 8'h66;  // 'f'
      default: ch = 8'h73;  // 's'
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pn_ram.sv
// pn_ram: generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module pn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/pn_ctrl.sv
// pn_ctrl: controller state machine of the path normaliser. Sequences the
// datapath through commands and owns the handshakes. Depends on pn_pkg.
`default_nettype none

module pn_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire pn_pkg::st_t st,
  output pn_pkg::ctl_t    ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHAR,
    S_LAST,
    S_SEG,
    S_WREQ,
    S_WCHK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   ret_done_r, ret_done_nxt;   // segment closed by the last beat
  state_t after_seg;

  assign after_seg = ret_done_r ? S_DONE : S_LAST;

  always_comb begin
    state_nxt      = state_r;
    ret_done_nxt   = ret_done_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    ctl.cmd        = pn_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.cmd   = pn_pkg::CMD_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.op_read) begin
          ctl.cmd   = pn_pkg::CMD_READ;
          state_nxt = S_DONE;
        end else begin
          unique case (st.kind)
            pn_pkg::BK_ROOT: begin
              ctl.cmd   = pn_pkg::CMD_ROOT;
              state_nxt = S_LAST;
            end
            pn_pkg::BK_SEP: begin
              ret_done_nxt = 1'b0;
              state_nxt    = S_SEG;
            end
            pn_pkg::BK_NEW: begin
              ctl.cmd   = pn_pkg::CMD_SLASH;
              state_nxt = S_CHAR;
            end
            pn_pkg::BK_MORE: begin
              ctl.cmd   = pn_pkg::CMD_CHAR;
              state_nxt = S_LAST;
            end
            default: begin
              state_nxt = S_LAST;
            end
          endcase
        end
      end
      S_CHAR: begin
        ctl.cmd   = pn_pkg::CMD_CHAR;
        state_nxt = S_LAST;
      end
      S_LAST: begin
        if (!st.is_last) begin
          state_nxt = S_DONE;
        end else begin
          ctl.cmd = pn_pkg::CMD_FIN;
          if (st.need_endseg) begin
            ret_done_nxt = 1'b1;
            state_nxt    = S_SEG;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SEG: begin
        ctl.cmd   = pn_pkg::CMD_SEG;
        state_nxt = st.seg_dotdot ? S_WREQ : after_seg;
      end
      S_WREQ: begin
        if (st.len_above_root) begin
          ctl.cmd   = pn_pkg::CMD_WREQ;
          state_nxt = S_WCHK;
        end else begin
          state_nxt = after_seg;
        end
      end
      S_WCHK: begin
        ctl.cmd   = pn_pkg::CMD_WSTEP;
        state_nxt = st.rd_slash ? after_seg : S_WREQ;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          ctl.cmd        = pn_pkg::CMD_LOAD;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      ret_done_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      ret_done_r   <= ret_done_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  // A rollback check always follows its read request.
  a_wchk_after_wreq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WCHK |-> $past(state_r) == S_WREQ)
    else $error("rollback check without a read request");

  // Loading the output register always presents a beat.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cmd == pn_pkg::CMD_LOAD |=> out_tvalid_r)
    else $error("output load did not raise out_tvalid");

endmodule

`default_nettype wire

// File: hw/rtl/pn_dp.sv
// pn_dp: datapath of the path normaliser: path state registers, the
// normalised-path buffer and the output register. Depends on pn_pkg and
// pn_ram.
`default_nettype none

module pn_dp #(
  parameter int unsigned PATH_MAX = pn_pkg::PATH_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [pn_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [0:0]                     in_tuser,
  input  wire logic                           in_tlast,
  input  wire pn_pkg::ctl_t                   ctl,
  output pn_pkg::st_t                         st,
  output logic      [pn_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // Room for a segment to run three bytes past the limit before it is judged.
  localparam int unsigned BUF_DEPTH = PATH_MAX + 4;
  localparam int unsigned AW        = $clog2(BUF_DEPTH);
  localparam int unsigned PAD_W     = pn_pkg::OUT_DATA_W - pn_pkg::OUT_FIELD_W;

  // Latched item.
  logic          op_r, op_nxt;
  logic [7:0]    c_r, c_nxt;
  logic          last_r, last_nxt;
  logic [7:0]    idx_r, idx_nxt;

  // Path state.
  logic [2:0]    pm_r, pm_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [1:0]    seg_r, seg_nxt;       // segment length, saturating at 3
  logic          dot1_r, dot1_nxt;     // first segment character is a dot
  logic          dot2_r, dot2_nxt;     // second segment character is a dot
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic          fin_r, fin_nxt;

  logic [pn_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Buffer port signals.
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rd_data;

  logic [AW-1:0] len_inc;
  logic [AW-1:0] len_dec;
  logic          seg_dotdot;
  logic          ok;
  logic          idx_hit;

  assign len_inc    = len_r + AW'(1);
  assign len_dec    = len_r - AW'(1);
  assign seg_dotdot = (seg_r == 2'd2) && dot1_r && dot2_r;
  assign ok         = fin_r && (err_r == pn_pkg::ERR_NONE);
  assign idx_hit    = 32'(idx_r) < 32'(len_r);

  pn_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr   (raddr),
    .rd_data (rd_data)
  );

  // Status towards the controller.
  always_comb begin
    st.op_read        = op_r;
    st.is_last        = last_r;
    st.need_endseg    = (err_r == pn_pkg::ERR_NONE) && (pm_r == pn_pkg::PM_ROOT);
    st.seg_dotdot     = seg_dotdot;
    st.len_above_root = 32'(len_r) > pn_pkg::ROOT_LEN;
    st.rd_slash       = (rd_data == pn_pkg::CH_SLASH);
    if (err_r != pn_pkg::ERR_NONE || pm_r >= pn_pkg::PM_ENDED) begin
      st.kind = pn_pkg::BK_SKIP;
    end else if (pm_r < pn_pkg::PM_ROOT) begin
      st.kind = pn_pkg::BK_ROOT;
    end else if (c_r == pn_pkg::CH_NUL || c_r == pn_pkg::CH_SLASH) begin
      st.kind = pn_pkg::BK_SEP;
    end else if (seg_r == 2'd0) begin
      st.kind = pn_pkg::BK_NEW;
    end else begin
      st.kind = pn_pkg::BK_MORE;
    end
  end

  always_comb begin
    op_nxt        = op_r;
    c_nxt         = c_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    pm_nxt        = pm_r;
    err_nxt       = err_r;
    seg_nxt       = seg_r;
    dot1_nxt      = dot1_r;
    dot2_nxt      = dot2_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    fin_nxt       = fin_r;
    out_tdata_nxt = out_tdata_r;
    we            = 1'b0;
    waddr         = len_r;
    wdata         = c_r;
    re            = 1'b0;
    raddr         = len_dec;
    unique case (ctl.cmd)
      pn_pkg::CMD_LATCH: begin
        op_nxt   = in_tuser[0];
        c_nxt    = in_tdata[7:0];
        last_nxt = in_tlast;
        idx_nxt  = in_tdata[15:8];
        // A push after a finished path begins a new one.
        if (!in_tuser[0] && fin_r) begin
          fin_nxt   = 1'b0;
          pm_nxt    = 3'd0;
          err_nxt   = pn_pkg::ERR_NONE;
          seg_nxt   = 2'd0;
          start_nxt = '0;
          len_nxt   = '0;
        end
      end
      pn_pkg::CMD_ROOT: begin
        if (c_r == pn_pkg::root_char(pm_r[1:0])) begin
          we     = 1'b1;
          waddr  = AW'(pm_r);
          pm_nxt = pm_r + 3'd1;
          if (pm_r == pn_pkg::PM_ROOT - 3'd1) begin
            len_nxt = AW'(pn_pkg::ROOT_LEN);
            seg_nxt = 2'd0;
          end
        end else begin
          err_nxt = pn_pkg::ERR_NO_ROOT;
        end
      end
      pn_pkg::CMD_SLASH: begin
        we        = 1'b1;
        wdata     = pn_pkg::CH_SLASH;
        start_nxt = len_r;
        len_nxt   = len_inc;
      end
      pn_pkg::CMD_CHAR: begin
        we      = 1'b1;
        len_nxt = len_inc;
        seg_nxt = (seg_r == 2'd3) ? seg_r : seg_r + 2'd1;
        if (seg_r == 2'd0) begin
          dot1_nxt = (c_r == pn_pkg::CH_DOT);
        end
        if (seg_r == 2'd1) begin
          dot2_nxt = (c_r == pn_pkg::CH_DOT);
        end
        // A segment of three or more characters is judged as it grows.
        if (seg_r >= 2'd2 && 32'(len_inc) >= PATH_MAX) begin
          err_nxt = pn_pkg::ERR_TOO_LONG;
        end
      end
      pn_pkg::CMD_FIN: begin
        fin_nxt = 1'b1;
        if (err_r == pn_pkg::ERR_NONE && pm_r < pn_pkg::PM_ROOT) begin
          err_nxt = pn_pkg::ERR_NO_ROOT;
        end
      end
      pn_pkg::CMD_SEG: begin
        if (seg_r != 2'd0) begin
          if ((seg_r == 2'd1 && dot1_r) || seg_dotdot) begin
            len_nxt = start_r;
          end else if (32'(len_r) >= PATH_MAX) begin
            err_nxt = pn_pkg::ERR_TOO_LONG;
          end
          seg_nxt = 2'd0;
        end
        // A zero byte after the root ends the path.
        if (c_r == pn_pkg::CH_NUL && pm_r == pn_pkg::PM_ROOT) begin
          pm_nxt = pn_pkg::PM_ENDED;
        end
      end
      pn_pkg::CMD_WREQ: begin
        re = 1'b1;
      end
      pn_pkg::CMD_WSTEP: begin
        len_nxt = len_dec;
      end
      pn_pkg::CMD_READ: begin
        re    = 1'b1;
        raddr = AW'(idx_r);
      end
      pn_pkg::CMD_LOAD: begin
        out_tdata_nxt = {
          {PAD_W{1'b0}},
          (op_r && ok && idx_hit) ? rd_data : 8'd0,
          ok ? 8'(len_r) : 8'd0,
          fin_r ? err_r : pn_pkg::ERR_NONE,
          fin_r
        };
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r    <= 3'd0;
      err_r   <= pn_pkg::ERR_NONE;
      seg_r   <= 2'd0;
      dot1_r  <= 1'b0;
      dot2_r  <= 1'b0;
      start_r <= '0;
      len_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      pm_r    <= pm_nxt;
      err_r   <= err_nxt;
      seg_r   <= seg_nxt;
      dot1_r  <= dot1_nxt;
      dot2_r  <= dot2_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    c_r         <= c_nxt;
    last_r      <= last_nxt;
    idx_r       <= idx_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tdata = out_tdata_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= PATH_MAX + 3)
    else $error("normalised length ran past the buffer margin");

  a_seg_after_root: assert property (@(posedge clk) disable iff (!rst_n)
    seg_r != 2'd0 |-> pm_r == pn_pkg::PM_ROOT)
    else $error("open segment outside the matched root");

  a_no_root_err: assert property (@(posedge clk) disable iff (!rst_n)
    err_r == pn_pkg::ERR_NO_ROOT |-> pm_r < pn_pkg::PM_ROOT)
    else $error("root error with the root fully matched");

endmodule

`default_nettype wire

// File: hw/rtl/path_normalizer.sv
// Path normaliser: a beat is latched, dispatched and loaded into the output;
// a push also passes a last-beat check, with a slash write first for a new
// segment or a segment close for a separator. A ".." rollback adds a read
// and a check per walked-back character at the one registered read port.
// Synchronous active-low reset clears all path state; the buffer is not
// cleared, so its contents are only meaningful once written.
// Depends on pn_pkg, pn_ctrl, pn_dp and pn_ram.
`default_nettype none

module path_normalizer #(
  parameter int unsigned PATH_MAX = pn_pkg::PATH_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel: one path character or one read request per beat.
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [pn_pkg::IN_DATA_W-1:0]  in_tdata,   // char_in[7:0], read_index[15:8]
  input  wire logic [0:0]                    in_tuser,   // opcode: 0 push, 1 read
  input  wire logic                          in_tlast,   // is_last
  // Result channel: one beat for every input beat.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [pn_pkg::OUT_DATA_W-1:0] out_tdata   // done_res[0], status[2:1],
                                                         // length[10:3], char_out[18:11]
);

  // The controller decides the order of work; the datapath holds the path
  // state, the buffer and the output register. They talk only through the
  // command and status structs below.
  pn_pkg::ctl_t ctl;
  pn_pkg::st_t  st;

  // The controller takes a new beat while the previous result still sits in
  // the output register; it only waits at the end of an item if that result
  // has not yet been taken.
  pn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .ctl        (ctl)
  );

  // The root "/lfs" is checked one character per beat and copied into the
  // buffer as it matches. Each kept segment is written as a slash followed
  // by its characters; "." and ".." are recognised from two flags, and ".."
  // walks back through the buffer to the previous slash, never below the
  // root.
  pn_dp #(
    .PATH_MAX (PATH_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .ctl       (ctl),
    .st        (st),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// File: tb/path_norm_checker.sv
// path_norm_checker: watches both stream channels of path_normalizer, keeps
// its own model of the normaliser state and compares every result beat.
// Depends on pn_pkg for widths, character constants and status codes.
`default_nettype none

module path_norm_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic                          in_tready,
  input  wire logic [pn_pkg::IN_DATA_W-1:0]  in_tdata,   // char_in[7:0], read_index[15:8]
  input  wire logic [0:0]                    in_tuser,   // opcode
  input  wire logic                          in_tlast,   // is_last
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [pn_pkg::OUT_DATA_W-1:0] out_tdata,  // done_res[0], status[2:1],
                                                         // length[10:3], char_out[18:11]
  output int                                 mismatches,
  output int                                 outstanding
);

  import pn_pkg::*;

  localparam logic        OP_PUSH    = 1'b0;
  localparam logic        OP_READ    = 1'b1;
  localparam int unsigned PATH_LIMIT = PATH_MAX_DEF;
  localparam int unsigned BUF_DEPTH  = PATH_LIMIT + 4;
  localparam logic [31:0] ROOT_PATH  = "/lfs";

  typedef struct packed {
    logic       done;
    logic [1:0] status;
    logic [7:0] length;
    logic [7:0] char_out;
  } result_t;

  logic [7:0]  path_buf [BUF_DEPTH];
  int unsigned path_len;
  int unsigned root_seen;   // root bytes matched, PM_ENDED once a zero byte ended the path
  int unsigned seg_base;
  int unsigned seg_len;
  logic [1:0]  path_err;
  logic        path_done;
  result_t     path_results [$];

  function automatic logic [7:0] root_byte(input int unsigned i);
    return ROOT_PATH[31 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] byte_at(input int unsigned i);
    return (i < BUF_DEPTH) ? path_buf[i] : CH_NUL;
  endfunction

  task automatic append(input logic [7:0] c);
    if (path_len < BUF_DEPTH) begin
      path_buf[path_len] = c;
      path_len++;
    end
  endtask

  task automatic clear_path();
    path_len  = 0;
    root_seen = 0;
    seg_base  = 0;
    seg_len   = 0;
    path_err  = ERR_NONE;
  endtask

  // Closes the segment in progress: "." vanishes, ".." walks back over the
  // previous component (never into the root), anything else is kept.
  task automatic close_segment();
    if (seg_len != 0) begin
      if (seg_len == 1 && byte_at(seg_base + 1) == CH_DOT) begin
        path_len = seg_base;
      end else if (seg_len == 2 && byte_at(seg_base + 1) == CH_DOT &&
                   byte_at(seg_base + 2) == CH_DOT) begin
        path_len = seg_base;
        while (path_len > ROOT_LEN && byte_at(path_len - 1) != CH_SLASH)
          path_len--;
        if (path_len > ROOT_LEN && byte_at(path_len - 1) == CH_SLASH)
          path_len--;
      end else if (path_len >= PATH_LIMIT) begin
        path_err = ERR_TOO_LONG;
      end
      seg_len = 0;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    int unsigned i;
    if (path_err == ERR_NONE && root_seen < PM_ENDED) begin
      if (root_seen < ROOT_LEN) begin
        if (c == root_byte(root_seen)) begin
          root_seen++;
          if (root_seen == ROOT_LEN) begin
            for (i = 0; i < ROOT_LEN; i++)
              path_buf[i] = root_byte(i);
            path_len = ROOT_LEN;
            seg_len  = 0;
          end
        end else begin
          path_err = ERR_NO_ROOT;
        end
      end else if (c == CH_NUL) begin
        close_segment();
        root_seen = PM_ENDED;
      end else if (c == CH_SLASH) begin
        close_segment();
      end else begin
        if (seg_len == 0) begin
          seg_base = path_len;
          append(CH_SLASH);
        end
        append(c);
        if (seg_len < 255)
          seg_len++;
        if (seg_len >= 3 && path_len >= PATH_LIMIT)
          path_err = ERR_TOO_LONG;
      end
    end
  endtask

  // Works out the result beat that one accepted input beat must produce.
  task automatic normalise_step(input logic op, input logic [7:0] c, input logic last,
                                input logic [7:0] idx);
    result_t r;
    logic    ok;
    if (op == OP_PUSH) begin
      if (path_done) begin
        clear_path();
        path_done = 1'b0;
      end
      take_char(c);
      if (last) begin
        if (path_err == ERR_NONE && root_seen < ROOT_LEN)
          path_err = ERR_NO_ROOT;
        if (path_err == ERR_NONE && root_seen == ROOT_LEN)
          close_segment();
        path_done = 1'b1;
      end
    end
    ok         = path_done && path_err == ERR_NONE;
    r.done     = path_done;
    r.status   = path_done ? path_err : ERR_NONE;
    r.length   = ok ? path_len[7:0] : 8'd0;
    r.char_out = (op == OP_READ && ok && idx < path_len) ? byte_at(idx) : 8'd0;
    path_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(input logic [OUT_DATA_W-1:0] beat);
    result_t want;
    if (path_results.size() == 0) begin
      $error("result beat %h arrived with no result outstanding", beat);
      mismatches++;
    end else begin
      want = path_results.pop_front();
      check_field("done_res", {7'd0, want.done}, {7'd0, beat[0]});
      check_field("status", {6'd0, want.status}, {6'd0, beat[2:1]});
      check_field("length", want.length, beat[10:3]);
      check_field("char_out", want.char_out, beat[18:11]);
      check_field("padding", 8'd0, {3'd0, beat[23:19]});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_path();
      path_done = 1'b0;
      foreach (path_buf[i]) path_buf[i] = CH_NUL;
      path_results.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (out_tvalid && out_tready)
        compare_result(out_tdata);
      if (in_tvalid && in_tready)
        normalise_step(in_tuser[0], in_tdata[7:0], in_tlast, in_tdata[15:8]);
      outstanding = path_results.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: drives path_normalizer with directed, long and random paths and
// read beats, with random idling on both sides, and reports the verdict.
// Depends on pn_pkg, path_normalizer and path_norm_checker.
`default_nettype none

module tb_top;

  import pn_pkg::*;

  localparam logic        OP_PUSH    = 1'b0;
  localparam logic        OP_READ    = 1'b1;
  localparam logic [31:0] ROOT_PATH  = "/lfs";
  localparam int unsigned RAND_BEATS = 600;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [0:0]            in_tuser   = 1'b0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatches;
  int                    outstanding;

  // Stimulus bookkeeping. gen_len follows the normalised length of the long
  // paths; fill_to adds only plain segments, so it stays exact.
  int unsigned           beats_sent  = 0;
  int unsigned           paths_sent  = 0;
  int unsigned           gen_len;
  int unsigned           last_seg;
  logic                  steady_send = 1'b0;
  logic [7:0]            path_bytes [$];

  always #5 clk = ~clk;

  path_normalizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  path_norm_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Offers one beat. Inputs only ever change at the falling edge; the
  // handshake is judged from the values seen at the rising edge. Idle cycles
  // may be inserted in front of the beat unless the steady stretch is on, and
  // tvalid is never lowered and raised in the same time step.
  task automatic send_beat(input logic op, input logic [7:0] ch, input logic last,
                           input logic [7:0] idx);
    @(negedge clk);
    while (!steady_send && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {idx, ch};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // The unused fields of push and read beats carry random values, so every
  // bit of every field is exercised on both kinds of beat.
  task automatic push_char(input logic [7:0] c, input logic last);
    send_beat(OP_PUSH, c, last, 8'($urandom_range(255)));
  endtask

  task automatic read_at(input logic [7:0] idx);
    send_beat(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), idx);
  endtask

  // Sender pause: nothing is offered until every result has come back.
  task automatic wait_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (c == CH_SLASH || c == CH_DOT);
    return c;
  endfunction

  task automatic push_root();
    int unsigned i;
    for (i = 0; i < ROOT_LEN; i++)
      push_char(ROOT_PATH[31 - 8*i -: 8], 1'b0);
    gen_len = ROOT_LEN;
  endtask

  // Appends plain segments until the normalised length reaches target
  // exactly. A remainder of one byte can never be filled, so segment sizes
  // are steered away from leaving one.
  task automatic fill_to(input int unsigned target, input logic last_at_end);
    int unsigned rem;
    int unsigned seg;
    int unsigned k;
    while (gen_len < target) begin
      rem = target - gen_len;
      if (rem <= 31) begin
        seg = rem - 1;
      end else begin
        seg = $urandom_range(30, 1);
        if (rem - seg - 1 == 1)
          seg++;
      end
      push_char(CH_SLASH, 1'b0);
      if ($urandom_range(7) == 0)
        push_char(CH_SLASH, 1'b0);
      for (k = 1; k <= seg; k++)
        push_char(plain_char(), last_at_end && k == seg && gen_len + seg + 1 == target);
      gen_len  = gen_len + seg + 1;
      last_seg = seg;
    end
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      path_bytes.push_back(s[i]);
  endtask

  // Pushes the bytes collected in path_bytes, the final one marked last.
  // Optionally a read beat is slipped in now and then ahead of a byte; one
  // slipped in after the first byte sees the path still open, not finished.
  task automatic send_path(input logic mixed_reads);
    int i;
    for (i = 0; i < path_bytes.size(); i++) begin
      if (mixed_reads && $urandom_range(24) == 0)
        read_at(8'($urandom_range(255)));
      push_char(path_bytes[i], i == path_bytes.size() - 1);
    end
    path_bytes.delete();
    paths_sent++;
  endtask

  // A well-formed path: the root followed by segments of ".", "..", dotty
  // names and ordinary names, separated by runs of slashes, sometimes with a
  // trailing slash or a terminating zero followed by bytes to be ignored.
  task automatic build_good_path();
    int unsigned i;
    int unsigned t;
    int unsigned ntok;
    int unsigned r;
    int unsigned n;
    queue_text("/lfs");
    ntok = $urandom_range(6);
    for (t = 0; t < ntok; t++) begin
      n = (t == 0 && $urandom_range(7) == 0) ? 0 : $urandom_range(2, 1);
      if ($urandom_range(15) == 0)
        n = 3;
      for (i = 0; i < n; i++)
        path_bytes.push_back(CH_SLASH);
      r = $urandom_range(99);
      if (r < 25) begin
        path_bytes.push_back(CH_DOT);
      end else if (r < 45) begin
        path_bytes.push_back(CH_DOT);
        path_bytes.push_back(CH_DOT);
      end else if (r < 55) begin
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++)
          path_bytes.push_back($urandom_range(1) ? CH_DOT : 8'h61);
      end else begin
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(5) == 0)
            path_bytes.push_back(8'($urandom_range(255, 1)) == CH_SLASH ? CH_DOT
                                                                          : plain_char());
          else
            path_bytes.push_back(8'h61 + 8'($urandom_range(25)));
        end
      end
    end
    if ($urandom_range(2) == 0)
      path_bytes.push_back(CH_SLASH);
    if ($urandom_range(9) == 0) begin
      path_bytes.push_back(CH_NUL);
      n = $urandom_range(3);
      for (i = 0; i < n; i++)
        path_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  // A broken path: either a proper prefix of the root that ends early, or a
  // prefix followed by a wrong byte (often zero) and some bytes after it.
  task automatic build_bad_path();
    int unsigned i;
    int unsigned n;
    logic [7:0]  c;
    if ($urandom_range(1)) begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++)
        path_bytes.push_back(ROOT_PATH[31 - 8*i -: 8]);
    end else begin
      n = $urandom_range(3);
      for (i = 0; i < n; i++)
        path_bytes.push_back(ROOT_PATH[31 - 8*i -: 8]);
      if ($urandom_range(3) == 0)
        c = CH_NUL;
      else
        do c = 8'($urandom_range(255)); while (c == ROOT_PATH[31 - 8*n -: 8]);
      path_bytes.push_back(c);
      n = $urandom_range(3);
      for (i = 0; i < n; i++)
        path_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  // Receiver. It runs on its own cycle count: one long hold-off while the
  // sender is busy with the first long path, so the block backs up and
  // stalls its input, a long stretch with no stalls at all, and otherwise
  // roughly a quarter of the cycles stalled at random.
  initial begin : receiver
    int unsigned cyc;
    cyc = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 1500 && cyc < 1900)
        out_tready <= 1'b0;
      else if (cyc >= 3000 && cyc < 4500)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(99) >= 26);
    end
  end

  initial begin : stimulus
    int unsigned rand_start;
    int unsigned r;
    int unsigned n;
    int unsigned i;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats. A read before any path has finished sees nothing.
    read_at(8'h00);
    // The bare root, then a read of its final character.
    queue_text("/lfs");
    send_path(1'b0);
    read_at(8'd3);
    // A path shorter than the root.
    queue_text("/lf");
    send_path(1'b0);
    // A zero byte while the root is still being matched.
    path_bytes.push_back(CH_NUL);
    send_path(1'b0);
    // The root test is a prefix test only: "/lfsx" is the root plus "x".
    // The second byte of that segment is the largest byte value.
    queue_text("/lfsx");
    path_bytes.push_back(8'hFF);
    send_path(1'b0);
    read_at(8'd6);
    // ".." straight after the root cannot climb above it, and a zero byte
    // ends the path so that the byte after it is ignored.
    queue_text("/lfs..");
    path_bytes.push_back(CH_NUL);
    path_bytes.push_back(8'h71);
    send_path(1'b0);

    // Long paths close to the length limit, with random segment contents.
    // First: a ".." whose bytes run past the limit is still rolled back, and
    // the path is then topped up to the longest length that is accepted.
    push_root();
    fill_to(253, 1'b0);
    push_char(CH_SLASH, 1'b0);
    push_char(CH_DOT, 1'b0);
    push_char(CH_DOT, 1'b0);
    push_char(CH_SLASH, 1'b0);
    gen_len = 253 - (last_seg + 1);
    fill_to(255, 1'b1);
    paths_sent++;
    read_at(8'd0);
    read_at(8'd254);
    read_at(8'd255);
    read_at(8'($urandom_range(253, 1)));
    wait_results();

    // Second: a two-byte segment crosses the limit and is only judged too
    // long when the next separator closes it; later bytes are ignored.
    push_root();
    fill_to(254, 1'b0);
    push_char(CH_SLASH, 1'b0);
    push_char(plain_char(), 1'b0);
    push_char(plain_char(), 1'b0);
    push_char(CH_SLASH, 1'b0);
    n = $urandom_range(3, 1);
    for (i = 1; i <= n; i++)
      push_char(8'($urandom_range(255)), i == n);
    paths_sent++;
    read_at(8'd4);

    // Third: a long segment crosses the limit while it is still growing.
    push_root();
    fill_to(240, 1'b0);
    push_char(CH_SLASH, 1'b0);
    for (i = 0; i < 30; i++)
      push_char(plain_char(), 1'b0);
    push_char(8'($urandom_range(255)), 1'b1);
    paths_sent++;
    read_at(8'd0);
    wait_results();

    // Random part: mostly well-formed paths, with broken roots, raw noise
    // and bare reads mixed in. One stretch of it is sent without idling.
    rand_start = beats_sent;
    while (beats_sent - rand_start < RAND_BEATS) begin
      steady_send = (beats_sent - rand_start >= 200 && beats_sent - rand_start < 350);
      r = $urandom_range(99);
      if (r < 70) begin
        build_good_path();
        send_path(1'b1);
      end else if (r < 82) begin
        build_bad_path();
        send_path(1'b1);
      end else if (r < 90) begin
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++)
          send_beat(1'($urandom_range(1)), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 8'($urandom_range(255)));
      end
      n = $urandom_range(3);
      for (i = 0; i < n; i++)
        read_at($urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'($urandom_range(24)));
      if ($urandom_range(9) == 0)
        wait_results();
    end
    steady_send = 1'b0;

    // Drain, then give the block some cycles to show any stray beat.
    wait_results();
    repeat (50) @(posedge clk);

    $display("Run covered %0d input beats over %0d paths, three of them at the %0d-byte limit,",
             beats_sent, paths_sent, PATH_MAX_DEF);
    $display("with random idling, a long receiver hold-off and sender pauses until drained.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the hold-off.
  initial begin : watchdog
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/pn_pkg.sv
hw/rtl/pn_ram.sv
hw/rtl/pn_ctrl.sv
hw/rtl/pn_dp.sv
hw/rtl/path_normalizer.sv
tb/path_norm_checker.sv
tb/tb_top.sv
